### src/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Entry layout, command struct between control and cell row, state codes
// and result kind codes.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int QUEUE_DEPTH     = 16;
   localparam int TIME_WIDTH      = 32;
   localparam int MAX_RESULTS     = 16;
   localparam int ID_WIDTH        = 16;
   localparam int ROUTINE_WIDTH   = 16;
   localparam int ARGUMENT_WIDTH  = 32;
   localparam int DRAIN_CNT_WIDTH = $clog2(MAX_RESULTS);

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_DUE    = 2'd2;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]     deadline;
      logic [ID_WIDTH-1:0]       id;
      logic [ROUTINE_WIDTH-1:0]  routine;
      logic [ARGUMENT_WIDTH-1:0] argument;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic pop;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_CALC,
      ST_ADD_INS,
      ST_TICK_INC,
      ST_TICK_DRAIN
   } dtq_state_type;

endpackage

### src/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted timer row
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's; on pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module dtq_cell
   import dtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    new_entry,
   input  logic         prev_keep,
   input  logic         prev_valid,
   input  entry_type    prev_entry,
   input  logic         next_valid,
   input  entry_type    next_entry,
   output logic         keep,
   output logic         valid,
   output entry_type    entry
);

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;

   // equal deadlines stay ahead of the new entry
   assign keep = valid_ff && (entry_ff.deadline <= new_entry.deadline);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!keep) begin
            if (prev_keep) begin
               valid_in = 1'b1;
               entry_in = new_entry;
            end else begin
               valid_in = prev_valid;
               entry_in = prev_entry;
            end
         end
      end else if (cmd.pop) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

### src/dtq_chain.sv
// ----------------------------------------------------------------------------
// dtq_chain: row of timer cells kept sorted by deadline
// Cell 0 is the head. Inserts ripple right from the insert point, pops shift
// everything one cell left.
// ----------------------------------------------------------------------------
module dtq_chain
   import dtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    new_entry,
   output logic         head_valid,
   output entry_type    head_entry,
   output logic         second_valid,
   output entry_type    second_entry,
   output logic         full
);

   logic      keep  [QUEUE_DEPTH];
   logic      valid [QUEUE_DEPTH];
   entry_type entry [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      left_keep;
      logic      left_valid;
      entry_type left_entry;
      logic      right_valid;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_valid = 1'b0;
         assign left_entry = new_entry;
      end else begin : g_body
         assign left_keep  = keep[i-1];
         assign left_valid = valid[i-1];
         assign left_entry = entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_valid = valid[i+1];
         assign right_entry = entry[i+1];
      end

      dtq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_entry  (new_entry),
         .prev_keep  (left_keep),
         .prev_valid (left_valid),
         .prev_entry (left_entry),
         .next_valid (right_valid),
         .next_entry (right_entry),
         .keep       (keep[i]),
         .valid      (valid[i]),
         .entry      (entry[i])
      );
   end

   assign head_valid   = valid[0];
   assign head_entry   = entry[0];
   assign second_valid = valid[1];
   assign second_entry = entry[1];
   assign full         = valid[QUEUE_DEPTH-1];

endmodule

### src/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue: deadline-ordered timer queue
// Add words insert a task sorted by deadline; tick words advance time and
// dispatch every due task, earliest first.
// ----------------------------------------------------------------------------
// Timing: one word at a time, busy while it is worked on. An add is busy for
// the deadline sum, then the insert into the cell row, and its single result
// strobes in the cycle after the insert. A tick is busy to advance the time,
// then while it dispatches due tasks, which leave through the head cell one
// per cycle; up to 16 tasks per tick. Results appear on rsp_valid for exactly
// one cycle each and cannot be held off; a new word may start while the last
// result shows.
// ----------------------------------------------------------------------------
module deadline_timer_queue
   import dtq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic                      req_relative,
   input  logic [31:0]               req_time_value,
   input  logic [ROUTINE_WIDTH-1:0]  req_routine_tag,
   input  logic [ARGUMENT_WIDTH-1:0] req_argument_tag,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_kind,
   output logic [ID_WIDTH-1:0]       rsp_task_id,
   output logic [ROUTINE_WIDTH-1:0]  rsp_due_routine,
   output logic [ARGUMENT_WIDTH-1:0] rsp_due_argument,
   output logic                      rsp_last
);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   dtq_state_type state_ff, state_in;

   logic                       relative_ff, relative_in;
   logic [TIME_WIDTH-1:0]      time_ff, time_in;
   logic [ROUTINE_WIDTH-1:0]   routine_ff, routine_in;
   logic [ARGUMENT_WIDTH-1:0]  argument_ff, argument_in;
   logic [TIME_WIDTH-1:0]      key_ff, key_in;
   logic [TIME_WIDTH-1:0]      now_ff, now_in;
   logic [ID_WIDTH-1:0]        next_id_ff, next_id_in;
   logic [DRAIN_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_kind_ff, rsp_kind_in;
   logic [ID_WIDTH-1:0]       rsp_task_id_ff, rsp_task_id_in;
   logic [ROUTINE_WIDTH-1:0]  rsp_routine_ff, rsp_routine_in;
   logic [ARGUMENT_WIDTH-1:0] rsp_argument_ff, rsp_argument_in;
   logic                      rsp_last_ff, rsp_last_in;

   cell_cmd_type cmd;
   entry_type    new_entry;
   logic         head_valid;
   entry_type    head_entry;
   logic         second_valid;
   entry_type    second_entry;
   logic         full;

   logic              accept;
   logic [TIME_WIDTH:0] sum;
   logic              head_due;
   logic              second_due;
   logic              drain_last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign sum        = {1'b0, now_ff} + {1'b0, time_ff};
   assign head_due   = head_valid && (head_entry.deadline <= now_ff);
   assign second_due = second_valid && (second_entry.deadline <= now_ff);
   assign drain_last = !second_due || (cnt_ff == DRAIN_CNT_WIDTH'(MAX_RESULTS - 1));

   assign new_entry.deadline = key_ff;
   assign new_entry.id       = next_id_ff;
   assign new_entry.routine  = routine_ff;
   assign new_entry.argument = argument_ff;

   dtq_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .new_entry    (new_entry),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .second_valid (second_valid),
      .second_entry (second_entry),
      .full         (full)
   );

   always_comb begin
      state_in        = state_ff;
      relative_in     = relative_ff;
      time_in         = time_ff;
      routine_in      = routine_ff;
      argument_in     = argument_ff;
      key_in          = key_ff;
      now_in          = now_ff;
      next_id_in      = next_id_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = 1'b0;
      rsp_kind_in     = rsp_kind_ff;
      rsp_task_id_in  = rsp_task_id_ff;
      rsp_routine_in  = rsp_routine_ff;
      rsp_argument_in = rsp_argument_ff;
      rsp_last_in     = rsp_last_ff;
      cmd             = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               relative_in = req_relative;
               time_in     = TIME_WIDTH'(req_time_value);
               routine_in  = req_routine_tag;
               argument_in = req_argument_tag;
               state_in    = req_func ? ST_TICK_INC : ST_ADD_CALC;
            end
         end
         ST_ADD_CALC: begin
            // saturate a relative deadline on carry out
            if (relative_ff) begin
               key_in = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
            end else begin
               key_in = time_ff;
            end
            state_in = ST_ADD_INS;
         end
         ST_ADD_INS: begin
            rsp_valid_in    = 1'b1;
            rsp_routine_in  = '0;
            rsp_argument_in = '0;
            rsp_last_in     = 1'b1;
            if (full) begin
               rsp_kind_in    = KIND_REJECT;
               rsp_task_id_in = '0;
            end else begin
               cmd.ins        = 1'b1;
               rsp_kind_in    = KIND_ACCEPT;
               rsp_task_id_in = next_id_ff;
               next_id_in     = next_id_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_TICK_INC: begin
            if (now_ff != TIME_MAX) begin
               now_in = now_ff + 1'b1;
            end
            cnt_in   = '0;
            state_in = ST_TICK_DRAIN;
         end
         ST_TICK_DRAIN: begin
            if (head_due) begin
               // dispatch the head and shift the row left
               cmd.pop         = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = KIND_DUE;
               rsp_task_id_in  = head_entry.id;
               rsp_routine_in  = head_entry.routine;
               rsp_argument_in = head_entry.argument;
               rsp_last_in     = drain_last;
               cnt_in          = cnt_ff + 1'b1;
               if (drain_last) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         next_id_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         next_id_ff   <= next_id_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      relative_ff     <= relative_in;
      time_ff         <= time_in;
      routine_ff      <= routine_in;
      argument_ff     <= argument_in;
      key_ff          <= key_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_task_id_ff  <= rsp_task_id_in;
      rsp_routine_ff  <= rsp_routine_in;
      rsp_argument_ff <= rsp_argument_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_task_id      = rsp_task_id_ff;
   assign rsp_due_routine  = rsp_routine_ff;
   assign rsp_due_argument = rsp_argument_ff;
   assign rsp_last         = rsp_last_ff;

   // results come only out of the insert and drain steps
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_ADD_INS || $past(state_ff) == ST_TICK_DRAIN))
      else $error("result strobe outside insert or drain");

   // an add answers with a single word
   a_add_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ACCEPT || rsp_kind == KIND_REJECT) |-> rsp_last)
      else $error("add result without last");

   // reject only when the row was full
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REJECT |-> $past(full))
      else $error("reject while the row had room");

   // a dispatched task was due at the current time
   a_due_time: assert property (@(posedge clock) disable iff (reset)
      $rose(cmd.pop) || cmd.pop |-> head_valid && (head_entry.deadline <= now_ff))
      else $error("pop of a task not yet due");

endmodule
